/* design/twlk_pkg.sv */
// shared constants, types and cosine tables for the tendon wire length core
package twlk_pkg;

  localparam int ANGLE_W    = 18;
  localparam int ANGLE_FRAC = 16;
  localparam int QF         = 30;
  localparam int ANGLE_SHIFT = QF - ANGLE_FRAC;

  localparam int RADIUS_W   = 31;
  localparam int JOINT_W    = 4;
  localparam int ALPHA_W    = 17;
  localparam int SLOPE_W    = 32;
  localparam int LIMIT_W    = 17;
  localparam int LEN_W      = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // cosine datapath
  localparam int ARG_W     = 34;
  localparam int RED_W     = ARG_W - 1;
  localparam int HALF_W    = 31;
  localparam int X2_W      = 32;
  localparam int T_W       = 31;
  localparam int COS_W     = 32;
  localparam int RECIP_W   = 34;
  localparam int COS_STEPS = 8;
  localparam int COS_LAT   = 2 + 2 * COS_STEPS;
  localparam int PIPE_DEPTH = COS_LAT + 3;

  localparam logic [RED_W-1:0]  PI_Q30      = 33'd3373259426;
  localparam logic [RED_W-1:0]  HALF_PI_Q30 = 33'd1686629713;
  localparam logic [RED_W-1:0]  TWO_PI_Q30  = 33'd6746518852;
  localparam logic [T_W-1:0]    T_ONE       = 31'h4000_0000;
  localparam logic signed [COS_W-1:0] COS_ONE = 32'sh4000_0000;

  // series steps run from the x^16 term down; each divides by (2k-1)*2k
  localparam int COS_SHIFT [COS_STEPS] = '{40, 40, 40, 39, 38, 37, 36, 33};
  localparam logic [RECIP_W-1:0] COS_RECIP [COS_STEPS] = '{
    RECIP_W'(((64'd1 << 40) + 64'd239) / 64'd240),
    RECIP_W'(((64'd1 << 40) + 64'd181) / 64'd182),
    RECIP_W'(((64'd1 << 40) + 64'd131) / 64'd132),
    RECIP_W'(((64'd1 << 39) + 64'd89) / 64'd90),
    RECIP_W'(((64'd1 << 38) + 64'd55) / 64'd56),
    RECIP_W'(((64'd1 << 37) + 64'd29) / 64'd30),
    RECIP_W'(((64'd1 << 36) + 64'd11) / 64'd12),
    RECIP_W'(((64'd1 << 33) + 64'd1) / 64'd2)
  };

  localparam logic [LEN_W-1:0]        OUT_LIMIT   = 31'd644245094;
  localparam logic signed [LEN_W-1:0] OUT_LIMIT_S = 31'sd644245094;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TUBE_RADIUS  = 3'd0,
    REG_JOINT_COUNT  = 3'd1,
    REG_ALPHA_WIDE   = 3'd2,
    REG_ALPHA_NARROW = 3'd3,
    REG_SLOPE_POS    = 3'd4,
    REG_SLOPE_NEG    = 3'd5,
    REG_SMALL_LIMIT  = 3'd6
  } twlk_reg_e;

  typedef struct packed {
    logic                  linear;
    logic                  pan_neg;
    logic                  tilt_neg;
    logic [3:0][LEN_W-1:0] lin;
  } twlk_side_t;

endpackage

/* design/twlk_if.sv */
// request and result channel interfaces of the tendon wire length core
interface twlk_in_if import twlk_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [ANGLE_W-1:0] pan_angle;
  logic signed [ANGLE_W-1:0] tilt_angle;

  modport source (output valid, output pan_angle, output tilt_angle, input ready);
  modport sink (input valid, input pan_angle, input tilt_angle, output ready);
endinterface

interface twlk_out_if import twlk_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [LEN_W-1:0] west_length;
  logic signed [LEN_W-1:0] east_length;
  logic signed [LEN_W-1:0] south_length;
  logic signed [LEN_W-1:0] north_length;

  modport source (output valid, output west_length, output east_length,
                  output south_length, output north_length, input ready);
  modport sink (input valid, input west_length, input east_length,
                input south_length, input north_length, output ready);
endinterface

/* design/twlk_cos.sv */
// pipelined q30 cosine: range fold, square, eight horner steps
module twlk_cos import twlk_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [ARG_W-1:0] arg_i,
  output logic signed [COS_W-1:0] cos_o
);

  logic [RED_W-1:0]  mag;
  logic [RED_W-1:0]  red;
  logic [HALF_W-1:0] folded;
  logic              fold_flip;

  logic [HALF_W-1:0] a_q;
  logic              f0_q;
  logic [X2_W-1:0]   x2_q;
  logic              f1_q;

  logic [2*HALF_W-1:0] sq;

  logic [X2_W-1:0]          step_x2 [COS_STEPS];
  logic [T_W-1:0]           step_t  [COS_STEPS];
  logic                     step_f  [COS_STEPS];
  logic [X2_W-1:0]          m_q     [COS_STEPS];
  logic [X2_W-1:0]          mx2_q   [COS_STEPS];
  logic                     mf_q    [COS_STEPS];
  logic signed [COS_W-1:0]  t_q     [COS_STEPS];
  logic [X2_W-1:0]          tx2_q   [COS_STEPS];
  logic                     tf_q    [COS_STEPS];

  // arguments stay below two pi, so only the folds are needed
  always_comb begin
    mag = arg_i[ARG_W-1] ? RED_W'(-arg_i) : RED_W'(arg_i);
    red = mag;
    if (red > PI_Q30) begin
      red = TWO_PI_Q30 - red;
    end
    fold_flip = 1'b0;
    folded    = HALF_W'(red);
    if (red > HALF_PI_Q30) begin
      folded    = HALF_W'(PI_Q30 - red);
      fold_flip = 1'b1;
    end
  end

  assign sq = a_q * a_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q  <= folded;
      f0_q <= fold_flip;
      x2_q <= sq[QF+X2_W-1:QF];
      f1_q <= f0_q;
    end
  end

  for (genvar i = 0; i < COS_STEPS; i++) begin : g_step
    logic [X2_W+T_W-1:0]     prod;
    logic [X2_W+RECIP_W-1:0] qp;
    logic [X2_W-1:0]         quo;

    if (i == 0) begin : g_first
      assign step_x2[i] = x2_q;
      assign step_t[i]  = T_ONE;
      assign step_f[i]  = f1_q;
    end else begin : g_next
      // inner terms stay within zero and one
      assign step_x2[i] = tx2_q[i-1];
      assign step_t[i]  = t_q[i-1][T_W-1:0];
      assign step_f[i]  = tf_q[i-1];
    end

    assign prod = step_x2[i] * step_t[i];
    assign qp   = m_q[i] * COS_RECIP[i];
    assign quo  = X2_W'(qp >> COS_SHIFT[i]);

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        m_q[i]   <= prod[QF+X2_W-1:QF];
        mx2_q[i] <= step_x2[i];
        mf_q[i]  <= step_f[i];
        t_q[i]   <= COS_ONE - $signed({1'b0, quo[T_W-1:0]});
        tx2_q[i] <= mx2_q[i];
        tf_q[i]  <= mf_q[i];
      end
    end
  end

  assign cos_o = tf_q[COS_STEPS-1] ? -t_q[COS_STEPS-1] : t_q[COS_STEPS-1];

endmodule

/* design/tendon_wire_length_kinematics_core.sv */
// tendon wire length kinematics core: pan/tilt angles to four wire length changes
//
//   channel | dir | handshake     | payload
//   in_i    | in  | valid/ready   | pan_angle, tilt_angle (Q2.16 rad)
//   out_o   | out | valid/ready   | west/east/south/north_length (2^-32 m)
//   cfg     | in  | cfg_we_i      | cfg_index_i, cfg_data_i
//
// one request per cycle while no untaken result stalls the pipe
// pipe depth set by the eight-step cosine series, two multiplier stages per step
// reset clears the valid bits and loads the register defaults
// a result left untaken freezes the whole pipe; nothing is dropped or repeated
module tendon_wire_length_kinematics_core import twlk_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  twlk_in_if.sink               in_i,
  twlk_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int LSL_W  = SLOPE_W + 1;
  localparam int LP_W   = LSL_W + ANGLE_W;
  localparam int D_W    = COS_W + 2;
  localparam int MAG_W  = 28;
  localparam int PROD_W = MAG_W + RADIUS_W;
  localparam int PJ_W   = PROD_W + JOINT_W;

  function automatic logic [LEN_W-1:0] lin_round(input logic signed [LP_W-1:0] p);
    logic [LP_W-1:0] m;
    logic [LP_W-1:0] r;
    logic [LEN_W-1:0] v;
    m = p[LP_W-1] ? LP_W'(-p) : LP_W'(p);
    r = (m + (LP_W'(1) << (ANGLE_FRAC - 1))) >> ANGLE_FRAC;
    v = (r > LP_W'(OUT_LIMIT)) ? OUT_LIMIT : LEN_W'(r);
    return p[LP_W-1] ? -v : v;
  endfunction

  function automatic logic [LEN_W-1:0] trig_len(input logic [PROD_W-1:0] pr,
                                                input logic [JOINT_W-1:0] j,
                                                input logic neg);
    logic [PJ_W-1:0] pj;
    logic [PJ_W:0]   r;
    logic [LEN_W-1:0] v;
    pj = pr * j;
    r  = ({pj, 1'b0} + (PJ_W'(1) << 23)) >> 24;
    v  = (r > (PJ_W+1)'(OUT_LIMIT)) ? OUT_LIMIT : LEN_W'(r);
    return neg ? -v : v;
  endfunction

  // configuration registers
  logic [RADIUS_W-1:0]       radius_q;
  logic [JOINT_W-1:0]        joints_q;
  logic [ALPHA_W-1:0]        alpha_wide_q;
  logic [ALPHA_W-1:0]        alpha_narrow_q;
  logic signed [SLOPE_W-1:0] slope_pos_q;
  logic signed [SLOPE_W-1:0] slope_neg_q;
  logic [LIMIT_W-1:0]        limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q       <= 31'd29721172;
      joints_q       <= 4'd5;
      alpha_wide_q   <= 17'd11422;
      alpha_narrow_q <= 17'd8548;
      slope_pos_q    <= 32'sd26407930;
      slope_neg_q    <= -32'sd18684175;
      limit_q        <= 17'd1144;
    end else if (cfg_we_i) begin
      unique case (twlk_reg_e'(cfg_index_i))
        REG_TUBE_RADIUS:  radius_q       <= cfg_data_i[RADIUS_W-1:0];
        REG_JOINT_COUNT:  joints_q       <= cfg_data_i[JOINT_W-1:0];
        REG_ALPHA_WIDE:   alpha_wide_q   <= cfg_data_i[ALPHA_W-1:0];
        REG_ALPHA_NARROW: alpha_narrow_q <= cfg_data_i[ALPHA_W-1:0];
        REG_SLOPE_POS:    slope_pos_q    <= $signed(cfg_data_i[SLOPE_W-1:0]);
        REG_SLOPE_NEG:    slope_neg_q    <= $signed(cfg_data_i[SLOPE_W-1:0]);
        REG_SMALL_LIMIT:  limit_q        <= cfg_data_i[LIMIT_W-1:0];
        default: begin end
      endcase
    end
  end

  // handshake and valid bits
  logic [PIPE_DEPTH-1:0] vld_q;
  logic                  en;
  logic                  accept;

  assign en          = !vld_q[PIPE_DEPTH-1] || out_o.ready;
  assign in_i.ready  = en;
  assign accept      = in_i.valid && en;
  assign out_o.valid = vld_q[PIPE_DEPTH-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_DEPTH-2:0], accept};
    end
  end

  // request decode
  logic signed [ANGLE_W-1:0] pan;
  logic signed [ANGLE_W-1:0] tilt;
  logic                      pan_neg;
  logic                      tilt_neg;
  logic signed [ARG_W-1:0]   aw;
  logic signed [ARG_W-1:0]   an;
  logic signed [ARG_W-1:0]   ph;
  logic signed [ARG_W-1:0]   th;
  logic signed [ARG_W-1:0]   cos_arg [8];
  logic signed [COS_W-1:0]   cos_val [8];

  assign pan      = in_i.pan_angle;
  assign tilt     = in_i.tilt_angle;
  assign pan_neg  = pan[ANGLE_W-1];
  assign tilt_neg = tilt[ANGLE_W-1];
  assign aw = ARG_W'({alpha_wide_q, {ANGLE_SHIFT{1'b0}}});
  assign an = ARG_W'({alpha_narrow_q, {ANGLE_SHIFT{1'b0}}});
  assign ph = ARG_W'(pan) <<< (ANGLE_SHIFT - 1);
  assign th = ARG_W'(tilt) <<< (ANGLE_SHIFT - 1);

  assign cos_arg[0] = aw;
  assign cos_arg[1] = an;
  assign cos_arg[2] = ph;
  assign cos_arg[3] = th;
  assign cos_arg[4] = (pan_neg ? aw : an) - ph;
  assign cos_arg[5] = (pan_neg ? an : aw) + ph;
  assign cos_arg[6] = (tilt_neg ? aw : an) - th;
  assign cos_arg[7] = (tilt_neg ? an : aw) + th;

  for (genvar c = 0; c < 8; c++) begin : g_cos
    twlk_cos u_cos (
      .clk_i (clk_i),
      .en_i  (en),
      .arg_i (cos_arg[c]),
      .cos_o (cos_val[c])
    );
  end

  // small-angle slope model
  logic signed [LIMIT_W+1:0] lim;
  logic signed [LIMIT_W+1:0] pan_x;
  logic signed [LIMIT_W+1:0] tilt_x;
  logic                      in_lin;
  logic signed [LSL_W-1:0]   sp;
  logic signed [LSL_W-1:0]   sn;
  logic signed [LSL_W-1:0]   lsl [4];
  logic signed [LP_W-1:0]    lp_q [4];
  logic                      lin0_q;
  logic                      pn0_q;
  logic                      tn0_q;

  assign lim    = $signed({2'b00, limit_q});
  assign pan_x  = (LIMIT_W+2)'(pan);
  assign tilt_x = (LIMIT_W+2)'(tilt);
  assign in_lin = (pan_x >= -lim) && (pan_x < lim) && (tilt_x >= -lim) && (tilt_x < lim);
  assign sp     = LSL_W'(slope_pos_q);
  assign sn     = LSL_W'(slope_neg_q);
  assign lsl[0] = pan_neg ? -sp : sn;
  assign lsl[1] = pan_neg ? -sn : sp;
  assign lsl[2] = tilt_neg ? -sp : sn;
  assign lsl[3] = tilt_neg ? -sn : sp;

  always_ff @(posedge clk_i) begin
    if (en) begin
      lp_q[0] <= lsl[0] * LP_W'(pan);
      lp_q[1] <= lsl[1] * LP_W'(pan);
      lp_q[2] <= lsl[2] * LP_W'(tilt);
      lp_q[3] <= lsl[3] * LP_W'(tilt);
      lin0_q  <= in_lin;
      pn0_q   <= pan_neg;
      tn0_q   <= tilt_neg;
    end
  end

  // side information travelling beside the cosine pipe
  twlk_side_t side_d;
  twlk_side_t side_q [1:PIPE_DEPTH-2];

  always_comb begin
    side_d.linear   = lin0_q;
    side_d.pan_neg  = pn0_q;
    side_d.tilt_neg = tn0_q;
    for (int w = 0; w < 4; w++) begin
      side_d.lin[w] = lin_round(lp_q[w]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[1] <= side_d;
      for (int i = 2; i <= PIPE_DEPTH - 2; i++) begin
        side_q[i] <= side_q[i-1];
      end
    end
  end

  // bracket, rounding to q24, scaling
  twlk_side_t              sc;
  logic signed [COS_W-1:0] ca  [4];
  logic signed [COS_W-1:0] co  [4];
  logic signed [D_W-1:0]   d   [4];
  logic [D_W-1:0]          dm  [4];
  logic [D_W-1:0]          dr  [4];
  logic [MAG_W-1:0]        mag_q  [4];
  logic                    neg_q  [4];
  logic [PROD_W-1:0]       prod_q [4];
  logic                    neg2_q [4];
  logic [LEN_W-1:0]        len_q  [4];

  assign sc    = side_q[COS_LAT-1];
  assign ca[0] = sc.pan_neg ? cos_val[0] : cos_val[1];
  assign ca[1] = sc.pan_neg ? cos_val[1] : cos_val[0];
  assign ca[2] = sc.tilt_neg ? cos_val[0] : cos_val[1];
  assign ca[3] = sc.tilt_neg ? cos_val[1] : cos_val[0];
  assign co[0] = cos_val[3];
  assign co[1] = cos_val[3];
  assign co[2] = cos_val[2];
  assign co[3] = cos_val[2];

  for (genvar w = 0; w < 4; w++) begin : g_wire
    assign d[w]  = D_W'(ca[w]) - D_W'(cos_val[4+w]) + D_W'(COS_ONE) - D_W'(co[w]);
    assign dm[w] = d[w][D_W-1] ? D_W'(-d[w]) : D_W'(d[w]);
    assign dr[w] = (dm[w] + D_W'(32)) >> 6;

    always_ff @(posedge clk_i) begin
      if (en) begin
        mag_q[w]  <= MAG_W'(dr[w]);
        neg_q[w]  <= d[w][D_W-1];
        prod_q[w] <= mag_q[w] * radius_q;
        neg2_q[w] <= neg_q[w];
        len_q[w]  <= side_q[PIPE_DEPTH-2].linear ? side_q[PIPE_DEPTH-2].lin[w]
                                                 : trig_len(prod_q[w], joints_q, neg2_q[w]);
      end
    end
  end

  assign out_o.west_length  = $signed(len_q[0]);
  assign out_o.east_length  = $signed(len_q[1]);
  assign out_o.south_length = $signed(len_q[2]);
  assign out_o.north_length = $signed(len_q[3]);

endmodule

/* design/twlk_checker.sv */
// port-level checks for the tendon wire length core and their binding
module twlk_checker import twlk_pkg::*; (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [LEN_W-1:0] west_length,
  input logic signed [LEN_W-1:0] east_length,
  input logic signed [LEN_W-1:0] south_length,
  input logic signed [LEN_W-1:0] north_length
);

  // no result may be shown while in reset
  a_reset_quiet: assert property (@(posedge clk_i) !rst_ni |-> !out_valid)
    else $error("result valid during reset");

  // requests are only held back by an untaken result
  a_no_bubble_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("request refused without an output stall");

  // a stalled result keeps its payload
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> (out_valid && $stable(west_length)
      && $stable(east_length) && $stable(south_length) && $stable(north_length)))
    else $error("stalled result changed");

  // every length stays within the saturation bound
  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (west_length <= OUT_LIMIT_S) && (west_length >= -OUT_LIMIT_S)
      && (east_length <= OUT_LIMIT_S) && (east_length >= -OUT_LIMIT_S)
      && (south_length <= OUT_LIMIT_S) && (south_length >= -OUT_LIMIT_S)
      && (north_length <= OUT_LIMIT_S) && (north_length >= -OUT_LIMIT_S))
    else $error("length outside saturation range");

endmodule

bind tendon_wire_length_kinematics_core twlk_checker u_twlk_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready     (in_i.ready),
  .out_valid    (out_o.valid),
  .out_ready    (out_o.ready),
  .west_length  (out_o.west_length),
  .east_length  (out_o.east_length),
  .south_length (out_o.south_length),
  .north_length (out_o.north_length)
);
